// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the point transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ----- hdl/hpt_pkg.sv -----
// Types and constants of the homogeneous point transform.
package hpt_pkg;

  localparam int ENTRY_W   = 32;  // one matrix entry, Q format signed
  localparam int REG_W     = 64;  // config register: two entries
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_LSB  = 3;   // registers on 8-byte strides
  localparam int ADDR_W    = REG_IDX_W + ADDR_LSB;
  localparam int PROD_W    = 64;
  localparam int SUM_W     = 66;  // exact sum of four products

  // identity matrix, 1.0 on the diagonal
  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;
  } out_beat_t;

endpackage

// ----- hdl/hpt_divider.sv -----
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
module hpt_divider #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [hpt_pkg::SUM_W-1:0]    num_i,
  input  logic [hpt_pkg::SUM_W-1:0]    den_i,
  output logic [COORD_WIDTH-1:0]       quot_o,
  output logic                         ovf_o
);

  localparam int SW = hpt_pkg::SUM_W;
  localparam int NW = SW + FRAC_BITS;
  localparam int CW = COORD_WIDTH;

  logic [NW-1:0] n_full;
  logic          ovf0;

  logic [SW-1:0] rem_q [CW+1];
  logic [SW-1:0] den_q [CW+1];
  logic [CW-1:0] low_q [CW+1];
  logic [CW-1:0] quo_q [CW+1];
  logic          ovf_q [CW+1];

  assign n_full = {num_i, FRAC_BITS'(0)};
  // quotient needs more than CW bits when the top part already reaches den
  assign ovf0   = NW'(n_full[NW-1:CW]) >= NW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= SW'(n_full[NW-1:CW]);
      den_q[0] <= den_i;
      low_q[0] <= n_full[CW-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= ovf0;
    end
  end

  for (genvar k = 1; k <= CW; k++) begin : g_step
    logic [SW:0]   trial;
    logic [SW+1:0] diff;
    logic          ge;

    assign trial = {rem_q[k-1], low_q[k-1][CW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_q[k-1]};
    assign ge    = !diff[SW+1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[SW-1:0] : trial[SW-1:0];
        den_q[k] <= den_q[k-1];
        low_q[k] <= {low_q[k-1][CW-2:0], 1'b0};
        quo_q[k] <= {quo_q[k-1][CW-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quot_o = quo_q[CW];
  assign ovf_o  = ovf_q[CW];

endmodule

// ----- hdl/homogeneous_point_transform.sv -----
// Top level: 4x4 homogeneous point transform with perspective divide.
// An accepted input beat passes the product, row-sum and magnitude registers, the divider and the output register.
// Throughput: one point per cycle when not stalled; pipelined divider, one quotient bit a stage.
// The pipeline advances as a whole and holds every stage while the output beat is stalled.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the identity matrix.
`include "assert_macros.svh"
module homogeneous_point_transform #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hpt_pkg::in_beat_t             in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hpt_pkg::out_beat_t            out_beat_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hpt_pkg::ADDR_W-1:0]    paddr,
  input  logic [hpt_pkg::REG_W-1:0]     pwdata,
  output logic [hpt_pkg::REG_W-1:0]     prdata,
  output logic                          pready
);

  localparam int SW      = hpt_pkg::SUM_W;
  localparam int EW      = hpt_pkg::ENTRY_W;
  localparam int PW      = hpt_pkg::PROD_W;
  localparam int CW      = COORD_WIDTH;
  localparam int DIV_LAT = CW + 1;
  // products, row sums, magnitudes, divider, output register
  localparam int LAT     = 3 + DIV_LAT + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic       wz;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [hpt_pkg::REG_W-1:0]     cfg_q [hpt_pkg::NUM_REGS];
  logic [hpt_pkg::REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[hpt_pkg::ADDR_W-1:hpt_pkg::ADDR_LSB];
  assign pready  = 1'b1;
  assign prdata  = cfg_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpt_pkg::NUM_REGS; i++) cfg_q[i] <= hpt_pkg::CFG_RESET[i];
    end else if (psel && penable && pwrite && pready) begin
      cfg_q[reg_idx] <= pwdata;
    end
  end

  // matrix entries: cols 0/1 in the even register, cols 2/3 in the odd one
  logic signed [EW-1:0] m [4][4];
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m[r][c] = cfg_q[2*r + c/2][(c%2)*EW +: EW];
    end
  end

  // ---------------- pipeline control ----------------
  logic [LAT-1:0] valid_q;
  logic           adv;

  // whole pipe moves unless a finished beat is waiting downstream
  assign adv         = !valid_q[LAT-1] || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[LAT-2:0], in_valid_i};
    end
  end

  // ---------------- stage 1: products ----------------
  // only the low COORD_WIDTH bits of a coordinate count
  logic signed [EW-1:0] coord [3];
  assign coord[0] = EW'(signed'(in_beat_i.in_x[CW-1:0]));
  assign coord[1] = EW'(signed'(in_beat_i.in_y[CW-1:0]));
  assign coord[2] = EW'(signed'(in_beat_i.in_z[CW-1:0]));

  logic signed [PW-1:0] prod_q [4][3];
  logic signed [PW-1:0] bias_q [4];  // column 3 times w = 1.0

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) prod_q[r][c] <= PW'(m[r][c]) * PW'(coord[c]);
        bias_q[r] <= PW'(m[r][3]) <<< FRAC_BITS;
      end
    end
  end

  // ---------------- stage 2: exact row sums ----------------
  logic signed [SW-1:0] p_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        p_q[r] <= SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2])
                + SW'(bias_q[r]);
      end
    end
  end

  // ---------------- stage 3: magnitudes and signs ----------------
  logic [SW-1:0] mag_q [4];
  side_t         side3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        mag_q[r] <= p_q[r][SW-1] ? SW'(-p_q[r]) : SW'(p_q[r]);
      end
      for (int r = 0; r < 3; r++) side3_q.neg[r] <= p_q[r][SW-1] ^ p_q[3][SW-1];
      side3_q.wz <= (p_q[3] == '0);
    end
  end

  // ---------------- divider lanes ----------------
  logic [CW-1:0] quot [3];
  logic          ovf  [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    hpt_divider #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_WIDTH(COORD_WIDTH)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mag_q[l]),
      .den_i (mag_q[3]),
      .quot_o(quot[l]),
      .ovf_o (ovf[l])
    );
  end

  // signs and the zero-w flag ride alongside the divider
  side_t side_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side3_q;
      for (int k = 1; k < DIV_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------- output stage: clamp and sign ----------------
  side_t                side_out;
  logic signed [31:0]   res   [3];
  logic [2:0]           clamp;

  assign side_out = side_q[DIV_LAT-1];

  for (genvar l = 0; l < 3; l++) begin : g_sat
    logic [CW-1:0] lim;
    logic [CW-1:0] mag;
    logic [CW-1:0] sgn;

    // negative results may reach one step further than positive ones
    assign lim      = {1'b0, {(CW-1){1'b1}}} + CW'(side_out.neg[l]);
    assign clamp[l] = ovf[l] || (quot[l] > lim);
    assign mag      = clamp[l] ? lim : quot[l];
    assign sgn      = side_out.neg[l] ? (~mag + CW'(1)) : mag;
    assign res[l]   = side_out.wz ? '0 : 32'(signed'(sgn));
  end

  hpt_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_x     <= res[0];
      out_q.out_y     <= res[1];
      out_q.out_z     <= res[2];
      out_q.w_zero    <= side_out.wz;
      out_q.saturated <= !side_out.wz && (|clamp);
    end
  end

  assign out_beat_o = out_q;

  // ---------------- assertions ----------------
  `ASSERT_AT(a_wzero_clears, clk_i, rst_ni, (out_valid_o && out_beat_o.w_zero |-> out_beat_o.out_x == 0 && out_beat_o.out_y == 0 && out_beat_o.out_z == 0 && !out_beat_o.saturated), "zero w beat carries nonzero data")
  `ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, in_stall_o, $stable(valid_q), "valid bits moved while stalled")
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, (in_valid_i && !in_stall_o), valid_q[0], "accepted beat lost at entry")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the homogeneous 4x4 point transform.
`timescale 1ns / 100ps
module testbench;

  localparam int FRAC = 16;
  localparam int LATENCY = 37;
  localparam int WATCHDOG_LIMIT = 5000;

  // register indexes, row-major, two entries per register
  typedef enum int {
    REG_R0_C01 = 0, REG_R0_C23 = 1, REG_R1_C01 = 2, REG_R1_C23 = 3,
    REG_R2_C01 = 4, REG_R2_C23 = 5, REG_R3_C01 = 6, REG_R3_C23 = 7
  } reg_idx_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  hpt_pkg::in_beat_t in_beat_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  hpt_pkg::out_beat_t out_beat_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [hpt_pkg::ADDR_W-1:0] paddr = '0;
  logic [hpt_pkg::REG_W-1:0] pwdata = '0;
  logic [hpt_pkg::REG_W-1:0] prdata;
  logic pready;

  always #5 clk_i = ~clk_i;

  homogeneous_point_transform dut (.*);

  // Local copy of the matrix, kept in step with every register write.
  logic signed [31:0] matrix [4][4];
  hpt_pkg::out_beat_t expected_points [$];
  int errors = 0;
  int idle_cycles = 0;
  bit allow_in_gaps = 1'b1, allow_out_gaps = 1'b1;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void load_matrix_reg(input int idx, input logic [63:0] val);
    int r;
    int c;
    r = idx / 2;
    c = (idx % 2) * 2;
    matrix[r][c] = val[31:0];
    matrix[r][c+1] = val[63:32];
  endfunction

  // Quotient num * 2^FRAC / den, truncated toward zero, clamped to 32 bits.
  function automatic logic [31:0] divide_clamp(input logic signed [65:0] num,
                                               input logic signed [65:0] den,
                                               inout bit clamped);
    logic [127:0] n_mag;
    logic [127:0] d_mag;
    logic [127:0] q;
    logic [127:0] lim;
    bit neg;
    neg = (num < 0) != (den < 0);
    n_mag = num < 0 ? 128'(-num) : 128'(num);
    d_mag = den < 0 ? 128'(-den) : 128'(den);
    q = (n_mag << FRAC) / d_mag;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) begin
      clamped = 1'b1;
      q = lim;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic hpt_pkg::out_beat_t transform_point(input hpt_pkg::in_beat_t p);
    logic signed [65:0] acc [4];
    logic signed [65:0] v [4];
    hpt_pkg::out_beat_t res;
    bit clamped;
    v[0] = p.in_x;
    v[1] = p.in_y;
    v[2] = p.in_z;
    v[3] = 66'sd65536;
    clamped = 1'b0;
    res = '0;
    for (int r = 0; r < 4; r++) begin
      acc[r] = '0;
      for (int c = 0; c < 4; c++) acc[r] += 66'(matrix[r][c]) * v[c];
    end
    if (acc[3] == 0) begin
      res.w_zero = 1'b1;
      return res;
    end
    res.out_x = divide_clamp(acc[0], acc[3], clamped);
    res.out_y = divide_clamp(acc[1], acc[3], clamped);
    res.out_z = divide_clamp(acc[2], acc[3], clamped);
    res.saturated = clamped;
    return res;
  endfunction

  // APB write: setup then access, pready is always high.
  task automatic write_reg(input int idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= hpt_pkg::ADDR_W'(idx << hpt_pkg::ADDR_LSB);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    load_matrix_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pack_row(input int a, input int b);
    return {32'(b), 32'(a)};
  endfunction

  // Drive one point; returns after it has been accepted.
  task automatic send_point(input hpt_pkg::in_beat_t p, input bit check_fixed,
                            input hpt_pkg::out_beat_t fixed);
    int gap;
    if (allow_in_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_points.push_back(check_fixed ? fixed : transform_point(p));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      3: return 32'($signed($urandom_range(0, 65535)) - 32768);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'h0001_0000;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      5: return 32'($signed($urandom_range(0, 4095)) - 2048) <<< 4;
      default: return $urandom;
    endcase
  endfunction

  // Output side: random stalls, compare against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          report("unexpected beat", 64'(out_beat_o), 64'h0);
        end else begin
          hpt_pkg::out_beat_t want;
          want = expected_points.pop_front();
          if (out_beat_o.out_x !== want.out_x) report("out_x", out_beat_o.out_x, want.out_x);
          if (out_beat_o.out_y !== want.out_y) report("out_y", out_beat_o.out_y, want.out_y);
          if (out_beat_o.out_z !== want.out_z) report("out_z", out_beat_o.out_z, want.out_z);
          if (out_beat_o.w_zero !== want.w_zero)
            report("w_zero", out_beat_o.w_zero, want.w_zero);
          if (out_beat_o.saturated !== want.saturated)
            report("saturated", out_beat_o.saturated, want.saturated);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!allow_out_gaps) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: cycles without any accepted beat on either channel or an APB select.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  typedef struct {
    hpt_pkg::in_beat_t pt;
    bit fixed;
    hpt_pkg::out_beat_t want;
  } directed_row_t;

  initial begin
    directed_row_t rows [$];
    hpt_pkg::out_beat_t z;
    hpt_pkg::in_beat_t p;
    int total;

    for (int i = 0; i < hpt_pkg::NUM_REGS; i++) load_matrix_reg(i, hpt_pkg::CFG_RESET[i]);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity after reset: points pass straight through.
    z = '0;
    z.out_x = 32'h0001_0000; z.out_y = 32'hffff_0000; z.out_z = 32'h0;
    rows.push_back('{'{32'h0001_0000, 32'hffff_0000, 32'h0}, 1'b1, z});
    z = '0;
    z.out_x = 32'h7fff_ffff; z.out_y = 32'h8000_0000; z.out_z = 32'h0000_0001;
    rows.push_back('{'{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001}, 1'b1, z});
    z = '0;
    z.out_x = 32'hffff_ffff; z.out_y = 32'h8000_0000; z.out_z = 32'h7fff_ffff;
    rows.push_back('{'{32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b1, z});
    foreach (rows[i]) send_point(rows[i].pt, rows[i].fixed, rows[i].want);
    in_valid_i <= 1'b0;
    wait_drained();

    // w row all zero: every point gives zero with the w_zero flag.
    write_reg(REG_R3_C01, 64'h0);
    write_reg(REG_R3_C23, 64'h0);
    rows.delete();
    z = '0;
    z.w_zero = 1'b1;
    rows.push_back('{'{32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff}, 1'b1, z});
    rows.push_back('{'{32'h0, 32'h0, 32'h0}, 1'b1, z});
    foreach (rows[i]) send_point(rows[i].pt, rows[i].fixed, rows[i].want);
    in_valid_i <= 1'b0;
    wait_drained();

    // Tiny w with large numerators: saturation both ways, plus w from z.
    write_reg(REG_R0_C01, pack_row(32'h7fff_ffff, 32'h8000_0000));
    write_reg(REG_R0_C23, pack_row(32'h7fff_ffff, 32'h7fff_ffff));
    write_reg(REG_R1_C01, pack_row(32'h8000_0000, 32'h7fff_ffff));
    write_reg(REG_R1_C23, pack_row(32'h8000_0000, 32'h8000_0000));
    write_reg(REG_R2_C01, pack_row(32'h0001_0000, 32'h0));
    write_reg(REG_R2_C23, pack_row(32'h0, 32'h0000_0003));
    write_reg(REG_R3_C01, pack_row(32'h0, 32'h0));
    write_reg(REG_R3_C23, pack_row(32'h0001_0000, 32'h0000_0001));
    rows.delete();
    z = '0;
    rows.push_back('{'{32'h0001_0000, 32'h0, 32'h0}, 1'b0, z});
    rows.push_back('{'{32'h7fff_ffff, 32'h8000_0000, 32'h0}, 1'b0, z});
    rows.push_back('{'{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff}, 1'b0, z});
    rows.push_back('{'{32'h0, 32'h0, 32'hffff_ffff}, 1'b0, z});
    rows.push_back('{'{32'h0003_0000, 32'hfffd_0000, 32'hfffe_0000}, 1'b0, z});
    rows.push_back('{'{32'h5555_5555, 32'haaaa_aaaa, 32'h8000_0000}, 1'b0, z});
    foreach (rows[i]) send_point(rows[i].pt, rows[i].fixed, rows[i].want);
    in_valid_i <= 1'b0;
    wait_drained();

    // Random matrices, one per phase; last phase runs with no gaps.
    total = 0;
    for (int phase = 0; phase < 14; phase++) begin
      for (int r = 0; r < hpt_pkg::NUM_REGS; r++) write_reg(r, {rand_entry(), rand_entry()});
      if (phase == 13) begin
        allow_in_gaps = 1'b0;
        allow_out_gaps = 1'b0;
      end
      for (int k = 0; k < 92; k++) begin
        p.in_x = rand_coord();
        p.in_y = rand_coord();
        p.in_z = rand_coord();
        send_point(p, 1'b0, z);
        total++;
        // hold off until the pipeline has fully drained, once
        if (phase == 5 && k == 40) begin
          in_valid_i <= 1'b0;
          while (expected_points.size() != 0) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/hpt_pkg.sv
hdl/hpt_divider.sv
hdl/homogeneous_point_transform.sv
verif/testbench.sv
